// ===== rtl/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// tlca_pkg: shared types and constants for the tree ancestor engine
// Field widths, item codes, datapath commands and the status bundle.
// ----------------------------------------------------------------------------
package tlca_pkg;

  // default sizes
  localparam int NODE_COUNT_DEF    = 4096;
  localparam int LIFT_LEVELS_DEF   = 12;
  localparam int EDGE_CAPACITY_DEF = 8192;

  // fixed item field widths
  localparam int MODE_W   = 2;
  localparam int ID_W     = 12;
  localparam int REL_W    = 2;
  localparam int COUNT_W  = 13;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 2;

  // item modes
  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // ignored, no result

  // result kinds
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // relation codes
  localparam logic [REL_W-1:0] REL_NONE = 2'd0;
  localparam logic [REL_W-1:0] REL_A    = 2'd1;
  localparam logic [REL_W-1:0] REL_B    = 2'd2;

  // register map
  localparam logic [CFG_AW-1:0] REG_ROOT = 2'd0;

  // datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_CLR_ALL,
    CMD_CLR,
    CMD_EDGE_FULL,
    CMD_E_RDA,
    CMD_E_WRA,
    CMD_E_RDB,
    CMD_E_WRB,
    CMD_B_ROOT,
    CMD_B_RDQ,
    CMD_B_RDP,
    CMD_B_HEAD,
    CMD_B_RDS,
    CMD_B_TGT,
    CMD_B_CHILD,
    CMD_B_RDA,
    CMD_B_LIFT,
    CMD_B_WRA,
    CMD_Q_RDX,
    CMD_Q_RDY,
    CMD_Q_ORDER,
    CMD_Q_RDAX,
    CMD_Q_UP,
    CMD_Q_STEP1,
    CMD_Q_K,
    CMD_Q_RDAY,
    CMD_Q_STEP2,
    CMD_Q_SAME,
    CMD_Q_FIN,
    CMD_RES_BUILD,
    CMD_RES_QUERY
  } cmd_t;

  // datapath status towards the controller
  typedef struct packed {
    logic clr_last;
    logic edge_bad;
    logic edge_full;
    logic root_bad;
    logic queue_empty;
    logic link_zero;
    logic child_ok;
    logic k_zero;
    logic k_full;
    logic xy_same;
  } status_t;

endpackage

// ===== rtl/tree_lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting: lowest common ancestor engine by binary lifting
// Builds a breadth-first ancestor table over an edge list and answers
// lowest common ancestor queries on it.
//
//   channel   ports                               direction  per item
//   in_*      mode, node_a, node_b                in         one edge, build or query
//   out_*     kind, ancestor, relation, count, ov out        one per build or query
//   cfg_*     APB write/read of root_node         in/out     one write or read
//
// Edge insert checks the endpoints and the store room, then reads and writes the
// head list for each direction. In a query each lifting step is a chain of
// registered reads of the ancestor and depth memories.
// A build first sweeps all nodes to clear depths and ancestor rows, then walks
// each queued node and its adjacency slots, and fills the LIFT_LEVELS ancestor
// row of every newly reached node.
// After reset a clearing pass over all nodes runs before in_ready rises.
// One item at a time; the next is accepted while a result still waits.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting
  import tlca_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int LIFT_LEVELS   = LIFT_LEVELS_DEF,
  parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [ID_W-1:0]    in_node_a,
  input  logic [ID_W-1:0]    in_node_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic [ID_W-1:0]    out_common_ancestor,
  output logic [REL_W-1:0]   out_relation,
  output logic [COUNT_W-1:0] out_reached_count,
  output logic               out_edge_overflow,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  logic [ID_W-1:0] root_r;
  cmd_t            cmd;
  status_t         st;

  // configuration: a single register, aliased across all addresses
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_ROOT) ? CFG_DW'(root_r) : CFG_DW'(root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= ID_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      root_r <= cfg_pwdata[ID_W-1:0];
    end
  end

  tlca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tlca_dpath #(
    .NODE_COUNT    (NODE_COUNT),
    .LIFT_LEVELS   (LIFT_LEVELS),
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_node_a           (in_node_a),
    .in_node_b           (in_node_b),
    .root_node           (root_r),
    .out_result_kind     (out_result_kind),
    .out_common_ancestor (out_common_ancestor),
    .out_relation        (out_relation),
    .out_reached_count   (out_reached_count),
    .out_edge_overflow   (out_edge_overflow)
  );

endmodule

// ===== rtl/tlca_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlca_ctrl: sequencer for the tree ancestor engine
// Steps the datapath through edge insert, breadth-first build and lifting
// query, and owns the item handshakes.
// ----------------------------------------------------------------------------
module tlca_ctrl
  import tlca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  status_t           st,
  output cmd_t              cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_E_CHK, S_E_WRA, S_E_RDB, S_E_WRB,
    S_B_CLR, S_B_ROOT, S_B_Q, S_B_P, S_B_H, S_B_L, S_B_T, S_B_D, S_B_A, S_B_W,
    S_RES_B,
    S_Q_RDX, S_Q_RDY, S_Q_ORD, S_Q_A, S_Q_U, S_Q_S1, S_Q_CMP,
    S_Q_B, S_Q_C, S_Q_S2, S_Q_F, S_Q_G, S_RES_Q
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      S_INIT: begin
        cmd = CMD_CLR_ALL;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LOAD;
          priority case (in_mode)
            MODE_EDGE:  state_nxt = S_E_CHK;
            MODE_BUILD: state_nxt = S_B_CLR;
            MODE_QUERY: state_nxt = S_Q_RDX;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      // edge insert
      S_E_CHK: begin
        if (st.edge_bad) begin
          state_nxt = S_IDLE;
        end else if (st.edge_full) begin
          cmd       = CMD_EDGE_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd       = CMD_E_RDA;
          state_nxt = S_E_WRA;
        end
      end
      S_E_WRA: begin cmd = CMD_E_WRA; state_nxt = S_E_RDB; end
      S_E_RDB: begin cmd = CMD_E_RDB; state_nxt = S_E_WRB; end
      S_E_WRB: begin cmd = CMD_E_WRB; state_nxt = S_IDLE;  end
      // build walk
      S_B_CLR: begin
        cmd = CMD_CLR;
        if (st.clr_last) state_nxt = S_B_ROOT;
      end
      S_B_ROOT: begin
        if (st.root_bad) begin
          state_nxt = S_RES_B;
        end else begin
          cmd       = CMD_B_ROOT;
          state_nxt = S_B_Q;
        end
      end
      S_B_Q: begin
        if (st.queue_empty) begin
          state_nxt = S_RES_B;
        end else begin
          cmd       = CMD_B_RDQ;
          state_nxt = S_B_P;
        end
      end
      S_B_P: begin cmd = CMD_B_RDP;  state_nxt = S_B_H; end
      S_B_H: begin cmd = CMD_B_HEAD; state_nxt = S_B_L; end
      S_B_L: begin
        if (st.link_zero) begin
          state_nxt = S_B_Q;
        end else begin
          cmd       = CMD_B_RDS;
          state_nxt = S_B_T;
        end
      end
      S_B_T: begin cmd = CMD_B_TGT; state_nxt = S_B_D; end
      S_B_D: begin
        if (st.child_ok) begin
          cmd       = CMD_B_CHILD;
          state_nxt = S_B_A;
        end else begin
          state_nxt = S_B_L;
        end
      end
      S_B_A: begin
        if (st.k_full) begin
          cmd       = CMD_B_WRA;
          state_nxt = S_B_L;
        end else begin
          cmd       = CMD_B_RDA;
          state_nxt = S_B_W;
        end
      end
      S_B_W: begin cmd = CMD_B_LIFT; state_nxt = S_B_A; end
      S_RES_B: begin
        if (slot_free) begin
          cmd       = CMD_RES_BUILD;
          state_nxt = S_IDLE;
        end
      end
      // query: level the deeper node, then lift both
      S_Q_RDX: begin cmd = CMD_Q_RDX;   state_nxt = S_Q_RDY; end
      S_Q_RDY: begin cmd = CMD_Q_RDY;   state_nxt = S_Q_ORD; end
      S_Q_ORD: begin cmd = CMD_Q_ORDER; state_nxt = S_Q_A;   end
      S_Q_A:   begin cmd = CMD_Q_RDAX;  state_nxt = S_Q_U;   end
      S_Q_U:   begin cmd = CMD_Q_UP;    state_nxt = S_Q_S1;  end
      S_Q_S1: begin
        cmd       = CMD_Q_STEP1;
        state_nxt = st.k_zero ? S_Q_CMP : S_Q_A;
      end
      S_Q_CMP: begin
        if (st.xy_same) begin
          cmd       = CMD_Q_SAME;
          state_nxt = S_RES_Q;
        end else begin
          cmd       = CMD_Q_K;
          state_nxt = S_Q_B;
        end
      end
      S_Q_B: begin cmd = CMD_Q_RDAX; state_nxt = S_Q_C;  end
      S_Q_C: begin cmd = CMD_Q_RDAY; state_nxt = S_Q_S2; end
      S_Q_S2: begin
        cmd       = CMD_Q_STEP2;
        state_nxt = st.k_zero ? S_Q_F : S_Q_B;
      end
      S_Q_F: begin cmd = CMD_Q_RDAX; state_nxt = S_Q_G;   end
      S_Q_G: begin cmd = CMD_Q_FIN;  state_nxt = S_RES_Q; end
      S_RES_Q: begin
        if (slot_free) begin
          cmd       = CMD_RES_QUERY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd == CMD_RES_BUILD || cmd == CMD_RES_QUERY) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result never overwrites one still waiting
  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_RES_BUILD || cmd == CMD_RES_QUERY) |-> (!out_valid_r || out_ready))
    else $error("result loaded into occupied slot");

  // a result load always shows up on the output
  a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_RES_BUILD || cmd == CMD_RES_QUERY) |=> out_valid_r)
    else $error("result not presented");

  // a real item drops in_ready in the cycle after it is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode != MODE_SPARE) |=> !in_ready)
    else $error("ready straight after accepting work");

endmodule

// ===== rtl/tlca_dpath.sv =====
// ----------------------------------------------------------------------------
// tlca_dpath: storage and working registers of the tree ancestor engine
// Adjacency lists, depths, ancestor rows and walk queue, each a memory with
// registered read data, plus the registers the sequencer steps through.
// ----------------------------------------------------------------------------
module tlca_dpath
  import tlca_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int LIFT_LEVELS   = LIFT_LEVELS_DEF,
  parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [ID_W-1:0]    in_node_a,
  input  logic [ID_W-1:0]    in_node_b,
  input  logic [ID_W-1:0]    root_node,
  output logic               out_result_kind,
  output logic [ID_W-1:0]    out_common_ancestor,
  output logic [REL_W-1:0]   out_relation,
  output logic [COUNT_W-1:0] out_reached_count,
  output logic               out_edge_overflow
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int DW = $clog2(NODE_COUNT + 1);
  localparam int EW = $clog2(EDGE_CAPACITY);
  localparam int HW = $clog2(EDGE_CAPACITY + 1);
  localparam int LW = $clog2(LIFT_LEVELS);
  localparam int KW = $clog2(LIFT_LEVELS + 1);

  typedef logic [LIFT_LEVELS-1:0][NW-1:0] row_t;

  // memories
  logic [HW-1:0] head_mem [NODE_COUNT];
  logic [HW-1:0] next_mem [EDGE_CAPACITY];
  logic [NW-1:0] tgt_mem  [EDGE_CAPACITY];
  logic [DW-1:0] depth_mem[NODE_COUNT];
  row_t          anc_mem  [NODE_COUNT];
  logic [NW-1:0] queue_mem[NODE_COUNT];

  logic [HW-1:0] head_q, next_q;
  logic [NW-1:0] tgt_q, queue_q;
  logic [DW-1:0] depth_q;
  row_t          anc_q;

  // control registers
  logic [NW-1:0] clr_r;
  logic [HW-1:0] total_r;
  logic          ovf_r;

  // working registers
  logic [ID_W-1:0] a_r, b_r;
  logic [NW-1:0]   qa_r, qb_r, x_r, y_r, p_r, j_r, up_r, s_r;
  logic [DW-1:0]   dx_r, dy_r, dp_r;
  logic [HW-1:0]   link_r;
  logic [CW-1:0]   rd_r, wr_r;
  logic [KW-1:0]   k_r;
  row_t            row_r, rowx_r;

  logic [NW-1:0] a_nw, b_nw, root_nw;
  logic [LW-1:0] k_i, km1_i;

  // port signals
  logic          head_we, depth_we, anc_we, queue_we, slot_we;
  logic [NW-1:0] head_wa, head_ra, depth_wa, depth_ra, anc_wa, anc_ra, queue_wa;
  logic [HW-1:0] head_wd, next_wd;
  logic [DW-1:0] depth_wd;
  row_t          anc_wd;
  logic [NW-1:0] queue_wd, tgt_wd;
  logic [EW-1:0] slot_wa, slot_ra;

  assign a_nw    = NW'(a_r);
  assign b_nw    = NW'(b_r);
  assign root_nw = NW'(root_node);
  assign k_i     = k_r[LW-1:0];
  assign km1_i   = LW'(k_r - 1'b1);

  // status
  assign st.clr_last    = (clr_r == NW'(NODE_COUNT - 1));
  assign st.edge_bad    = (32'(a_r) >= NODE_COUNT) || (32'(b_r) >= NODE_COUNT);
  assign st.edge_full   = ((HW + 1)'(total_r) + (HW + 1)'(2)) > (HW + 1)'(EDGE_CAPACITY);
  assign st.root_bad    = (root_node == '0) || (32'(root_node) >= NODE_COUNT);
  assign st.queue_empty = (rd_r == wr_r);
  assign st.link_zero   = (link_r == '0);
  assign st.child_ok    = (j_r != '0) && (depth_q == '0) && (32'(wr_r) < NODE_COUNT);
  assign st.k_zero      = (k_r == '0);
  assign st.k_full      = (k_r == KW'(LIFT_LEVELS));
  assign st.xy_same     = (x_r == y_r);

  // memory port steering
  always_comb begin
    head_we  = 1'b0; head_wa  = '0; head_wd  = '0; head_ra = a_nw;
    slot_we  = 1'b0; slot_wa  = '0; tgt_wd   = '0; next_wd = '0;
    slot_ra  = EW'(link_r - 1'b1);
    depth_we = 1'b0; depth_wa = '0; depth_wd = '0; depth_ra = x_r;
    anc_we   = 1'b0; anc_wa   = '0; anc_wd   = '0; anc_ra  = x_r;
    queue_we = 1'b0; queue_wa = '0; queue_wd = '0;
    unique case (cmd)
      CMD_CLR_ALL: begin
        head_we  = 1'b1; head_wa  = clr_r;
        depth_we = 1'b1; depth_wa = clr_r;
        anc_we   = 1'b1; anc_wa   = clr_r;
      end
      CMD_CLR: begin
        depth_we = 1'b1; depth_wa = clr_r;
        anc_we   = 1'b1; anc_wa   = clr_r;
      end
      CMD_E_RDA: head_ra = a_nw;
      CMD_E_WRA: begin
        head_we = 1'b1; head_wa = a_nw; head_wd = total_r + 1'b1;
        slot_we = 1'b1; slot_wa = EW'(total_r); tgt_wd = b_nw; next_wd = head_q;
      end
      CMD_E_RDB: head_ra = b_nw;
      CMD_E_WRB: begin
        head_we = 1'b1; head_wa = b_nw; head_wd = total_r + HW'(2);
        slot_we = 1'b1; slot_wa = EW'(total_r + 1'b1); tgt_wd = a_nw; next_wd = head_q;
      end
      CMD_B_ROOT: begin
        depth_we = 1'b1; depth_wa = root_nw; depth_wd = DW'(1);
        queue_we = 1'b1; queue_wa = '0;      queue_wd = root_nw;
      end
      CMD_B_RDP: begin
        head_ra  = queue_q;
        depth_ra = queue_q;
      end
      CMD_B_TGT: depth_ra = tgt_q;
      CMD_B_CHILD: begin
        depth_we = 1'b1; depth_wa = j_r;          depth_wd = dp_r + 1'b1;
        queue_we = 1'b1; queue_wa = NW'(wr_r);    queue_wd = j_r;
      end
      CMD_B_RDA: anc_ra = row_r[km1_i];
      CMD_B_WRA: begin
        anc_we = 1'b1; anc_wa = j_r; anc_wd = row_r;
      end
      CMD_Q_RDX:  depth_ra = x_r;
      CMD_Q_RDY:  depth_ra = y_r;
      CMD_Q_RDAX: anc_ra   = x_r;
      CMD_Q_UP:   depth_ra = anc_q[k_i];
      CMD_Q_RDAY: anc_ra   = y_r;
      default: ;
    endcase
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      next_mem[slot_wa] <= next_wd;
      tgt_mem[slot_wa]  <= tgt_wd;
    end
    next_q <= next_mem[slot_ra];
    tgt_q  <= tgt_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (depth_we) depth_mem[depth_wa] <= depth_wd;
    depth_q <= depth_mem[depth_ra];
  end

  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    anc_q <= anc_mem[anc_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_q <= queue_mem[NW'(rd_r)];
  end

  // clear sweep index, edge count, overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd == CMD_CLR_ALL || cmd == CMD_CLR) begin
        clr_r <= st.clr_last ? '0 : clr_r + 1'b1;
      end
      if (cmd == CMD_E_WRB)     total_r <= total_r + HW'(2);
      if (cmd == CMD_EDGE_FULL) ovf_r   <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        a_r  <= in_node_a;
        b_r  <= in_node_b;
        qa_r <= (32'(in_node_a) >= NODE_COUNT) ? '0 : NW'(in_node_a);
        qb_r <= (32'(in_node_b) >= NODE_COUNT) ? '0 : NW'(in_node_b);
        x_r  <= (32'(in_node_a) >= NODE_COUNT) ? '0 : NW'(in_node_a);
        y_r  <= (32'(in_node_b) >= NODE_COUNT) ? '0 : NW'(in_node_b);
        rd_r <= '0;
        wr_r <= '0;
      end
      CMD_B_ROOT: wr_r <= CW'(1);
      CMD_B_RDQ:  rd_r <= rd_r + 1'b1;
      CMD_B_RDP:  p_r  <= queue_q;
      CMD_B_HEAD: begin
        link_r <= head_q;
        dp_r   <= depth_q;
      end
      CMD_B_TGT: begin
        j_r    <= tgt_q;
        link_r <= next_q;
      end
      CMD_B_CHILD: begin
        wr_r  <= wr_r + 1'b1;
        // parent in level zero, higher levels filled by the lift steps
        row_r <= row_t'({{((LIFT_LEVELS - 1) * NW){1'b0}}, p_r});
        k_r   <= KW'(1);
      end
      CMD_B_LIFT: begin
        row_r[k_i] <= anc_q[km1_i];
        k_r        <= k_r + 1'b1;
      end
      CMD_Q_RDY: dx_r <= depth_q;
      CMD_Q_ORDER: begin
        if (dx_r < depth_q) begin
          x_r  <= y_r;
          y_r  <= x_r;
          dy_r <= dx_r;
        end else begin
          dy_r <= depth_q;
        end
        k_r <= KW'(LIFT_LEVELS - 1);
      end
      CMD_Q_UP: up_r <= anc_q[k_i];
      CMD_Q_STEP1: begin
        if (depth_q >= dy_r) x_r <= up_r;
        k_r <= k_r - 1'b1;
      end
      CMD_Q_K:    k_r    <= KW'(LIFT_LEVELS - 1);
      CMD_Q_RDAY: rowx_r <= anc_q;
      CMD_Q_STEP2: begin
        if (rowx_r[k_i] != anc_q[k_i]) begin
          x_r <= rowx_r[k_i];
          y_r <= anc_q[k_i];
        end
        k_r <= k_r - 1'b1;
      end
      CMD_Q_SAME: s_r <= x_r;
      CMD_Q_FIN:  s_r <= anc_q[0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd == CMD_RES_BUILD) begin
      out_result_kind     <= KIND_BUILD;
      out_common_ancestor <= '0;
      out_relation        <= REL_NONE;
      out_reached_count   <= COUNT_W'(wr_r);
      out_edge_overflow   <= ovf_r;
    end else if (cmd == CMD_RES_QUERY) begin
      out_result_kind     <= KIND_QUERY;
      out_common_ancestor <= ID_W'(s_r);
      out_relation        <= (s_r == qa_r) ? REL_A : ((s_r == qb_r) ? REL_B : REL_NONE);
      out_reached_count   <= '0;
      out_edge_overflow   <= ovf_r;
    end
  end

  // the walk queue never takes more nodes than it holds
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_B_CHILD) |-> (32'(wr_r) < NODE_COUNT))
    else $error("walk queue overrun");

  // the slot count stays within capacity
  a_slot_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_E_WRB) |=> (32'(total_r) <= EDGE_CAPACITY))
    else $error("edge store overrun");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the tree ancestor engine
// Runs a table of directed items, then random rounds. Each round sets the
// root, adds a random tree plus noise, builds and queries. A last phase builds
// a larger tree. Results are checked against the table's typed answers or a
// predictor of the adjacency store, the breadth-first build and the lifting query.
// ----------------------------------------------------------------------------
module tb_top;
  import tlca_pkg::*;

  localparam int NODES  = 4096;
  localparam int LEVELS = 12;
  localparam int SLOTS  = 8192;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    anc;
    logic [REL_W-1:0]   rel;
    logic [COUNT_W-1:0] cnt;
    logic               ov;
  } answer_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    int                a;
    int                b;
    bit                typed;
    answer_t           ans;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [MODE_W-1:0]  in_mode;
  logic [ID_W-1:0]    in_node_a;
  logic [ID_W-1:0]    in_node_b;
  logic               out_valid;
  logic               out_ready;
  logic               out_result_kind;
  logic [ID_W-1:0]    out_common_ancestor;
  logic [REL_W-1:0]   out_relation;
  logic [COUNT_W-1:0] out_reached_count;
  logic               out_edge_overflow;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [CFG_DW-1:0]  cfg_pwdata;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  tree_lca_binary_lifting DUT (.*);

  // predictor state
  int       root_sel;
  int       list_head [NODES];
  int       slot_next [SLOTS];
  int       slot_tgt  [SLOTS];
  int       slots_used;
  bit       store_ovf;
  int       node_lvl  [NODES];
  int       lift_tab  [NODES][LEVELS];
  int       bfs_order [NODES];

  answer_t  pending_answers [$];
  row_t     directed [$];
  int       errors;
  bit       calm;
  bit       hold_req;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timeout
  initial begin
    #24000000;
    $display("Test completed with failures");
    $finish;
  end

  // adjacency store: two slots per edge, newest at head of list
  function automatic void store_edge(int a, int b);
    if (slots_used + 2 > SLOTS) begin
      store_ovf = 1'b1;
      return;
    end
    slot_tgt[slots_used]  = b;
    slot_next[slots_used] = list_head[a];
    list_head[a]          = slots_used + 1;
    slots_used++;
    slot_tgt[slots_used]  = a;
    slot_next[slots_used] = list_head[b];
    list_head[b]          = slots_used + 1;
    slots_used++;
  endfunction

  // breadth-first walk from the root, filling levels and lift table
  function automatic int walk_tree();
    int rd, wr, p, link, s, j;
    rd = 0;
    wr = 0;
    for (int n = 0; n < NODES; n++) begin
      node_lvl[n] = 0;
      for (int k = 0; k < LEVELS; k++) lift_tab[n][k] = 0;
    end
    if (root_sel == 0 || root_sel >= NODES) return 0;
    node_lvl[root_sel] = 1;
    bfs_order[wr] = root_sel;
    wr++;
    while (rd < wr) begin
      p = bfs_order[rd];
      rd++;
      link = list_head[p];
      while (link != 0) begin
        s = link - 1;
        j = slot_tgt[s];
        if (j != 0 && node_lvl[j] == 0 && wr < NODES) begin
          node_lvl[j] = node_lvl[p] + 1;
          bfs_order[wr] = j;
          wr++;
          lift_tab[j][0] = p;
          for (int k = 1; k < LEVELS; k++)
            lift_tab[j][k] = lift_tab[lift_tab[j][k-1]][k-1];
        end
        link = slot_next[s];
      end
    end
    return wr;
  endfunction

  // lowest common ancestor by lifting
  function automatic int lift_common(int x, int y);
    int t;
    if (node_lvl[x] < node_lvl[y]) begin
      t = x;
      x = y;
      y = t;
    end
    for (int k = LEVELS - 1; k >= 0; k--)
      if (node_lvl[lift_tab[x][k]] >= node_lvl[y]) x = lift_tab[x][k];
    if (x == y) return x;
    for (int k = LEVELS - 1; k >= 0; k--)
      if (lift_tab[x][k] != lift_tab[y][k]) begin
        x = lift_tab[x][k];
        y = lift_tab[y][k];
      end
    return lift_tab[x][0];
  endfunction

  function automatic bit predict_answer(logic [MODE_W-1:0] m, int a, int b,
                                        output answer_t r);
    int c;
    r = '0;
    case (m)
      MODE_EDGE: begin
        store_edge(a, b);
        return 1'b0;
      end
      MODE_BUILD: begin
        r.kind = KIND_BUILD;
        r.cnt  = COUNT_W'(walk_tree());
        r.ov   = store_ovf;
        return 1'b1;
      end
      MODE_QUERY: begin
        c      = lift_common(a, b);
        r.kind = KIND_QUERY;
        r.anc  = ID_W'(c);
        r.rel  = (c == a) ? REL_A : ((c == b) ? REL_B : REL_NONE);
        r.ov   = store_ovf;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // offer one item, predict once accepted
  task automatic send_item(logic [MODE_W-1:0] m, int a, int b,
                           bit typed = 1'b0, answer_t ta = '0);
    answer_t got;
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid  = 1'b1;
    in_mode   = m;
    in_node_a = ID_W'(a);
    in_node_b = ID_W'(b);
    do @(posedge clk); while (!in_ready);
    if (predict_answer(m, a, b, got)) pending_answers.push_back(typed ? ta : got);
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_root(int v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = REG_ROOT;
    cfg_pwdata  = v;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    root_sel = v & 32'hfff;
    // read back
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata !== CFG_DW'(root_sel)) begin
      $display("%0t root readback: expected %0d actual %0d", $time, root_sel, cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_field(string name, int e, int g);
    if (e != g) begin
      $display("%0t %s: expected %0d actual %0d", $time, name, e, g);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result: expected none actual kind %0d", $time,
                 out_result_kind);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        check_field("result_kind", e.kind, out_result_kind);
        check_field("common_ancestor", e.anc, out_common_ancestor);
        check_field("relation", e.rel, out_relation);
        check_field("reached_count", e.cnt, out_reached_count);
        check_field("edge_overflow", e.ov, out_edge_overflow);
      end
    end
  end

  // result side back-pressure, with one long hold-off
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        held = 1'b1;
      end
      out_ready = calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // stimulus
  initial begin
    int ids [$];
    int n, r, a, b;
    errors      = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = MODE_EDGE;
    in_node_a   = '0;
    in_node_b   = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    root_sel    = 1;
    slots_used  = 0;
    store_ovf   = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      list_head[i] = 0;
      node_lvl[i]  = 0;
      for (int k = 0; k < LEVELS; k++) lift_tab[i][k] = 0;
    end

    // directed table
    directed.push_back('{MODE_QUERY, 0, 0, 1'b1, '{KIND_QUERY, 12'd0, REL_A, 13'd0, 1'b0}});
    directed.push_back('{MODE_BUILD, 0, 0, 1'b1, '{KIND_BUILD, 12'd0, REL_NONE, 13'd1, 1'b0}});
    directed.push_back('{MODE_EDGE, 1, 2, 1'b0, '0});
    directed.push_back('{MODE_EDGE, 2, 3, 1'b0, '0});
    directed.push_back('{MODE_EDGE, 1, 4095, 1'b0, '0});
    directed.push_back('{MODE_EDGE, 3, 3, 1'b0, '0});       // self loop
    directed.push_back('{MODE_EDGE, 2, 1, 1'b0, '0});       // duplicate edge
    directed.push_back('{MODE_SPARE, 4095, 4095, 1'b0, '0}); // unused mode
    directed.push_back('{MODE_EDGE, 5, 0, 1'b0, '0});       // sentinel endpoint
    directed.push_back('{MODE_EDGE, 4095, 4094, 1'b0, '0});
    directed.push_back('{MODE_BUILD, 0, 0, 1'b1, '{KIND_BUILD, 12'd0, REL_NONE, 13'd5, 1'b0}});
    directed.push_back('{MODE_QUERY, 1, 3, 1'b1, '{KIND_QUERY, 12'd1, REL_A, 13'd0, 1'b0}});
    directed.push_back('{MODE_QUERY, 4094, 4095, 1'b1,
                         '{KIND_QUERY, 12'd4095, REL_B, 13'd0, 1'b0}});
    directed.push_back('{MODE_QUERY, 2, 2, 1'b1, '{KIND_QUERY, 12'd2, REL_A, 13'd0, 1'b0}});
    directed.push_back('{MODE_QUERY, 3, 4094, 1'b0, '0});
    directed.push_back('{MODE_QUERY, 5, 3, 1'b0, '0});     // unreached node
    directed.push_back('{MODE_QUERY, 4095, 0, 1'b0, '0});
    directed.push_back('{MODE_QUERY, 4095, 4095, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].a, directed[i].b,
                directed[i].typed, directed[i].ans);
    settle();

    // random rounds: root, tree with noise, build, queries
    for (r = 0; r < 8; r++) begin
      ids.delete();
      n = $urandom_range(2, 40);
      for (int i = 0; i < n; i++) ids.push_back($urandom_range(1, NODES - 1));
      if (r == 0) ids[0] = NODES - 1;
      set_root(r == 1 ? 0 : ids[0]);
      hold_req = (r == 2);
      calm     = (r == 4);
      for (int i = 1; i < n; i++) begin
        a = ids[i];
        b = ids[$urandom_range(0, i - 1)];
        if ($urandom_range(0, 1)) send_item(MODE_EDGE, a, b);
        else send_item(MODE_EDGE, b, a);
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 3))
            0: send_item(MODE_EDGE, a, a);
            1: send_item(MODE_EDGE, a, ids[$urandom_range(0, i)]);
            2: send_item(MODE_EDGE, 0, a);
            default: send_item(MODE_SPARE, $urandom_range(0, NODES - 1),
                               $urandom_range(0, NODES - 1));
          endcase
        end
      end
      send_item(MODE_BUILD, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
      for (int q = 0; q < 75; q++) begin
        if ($urandom_range(0, 99) < 80)
          send_item(MODE_QUERY, ids[$urandom_range(0, n - 1)], ids[$urandom_range(0, n - 1)]);
        else
          send_item(MODE_QUERY, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
      end
      settle();
    end
    calm = 1'b0;

    // one larger tree rooted at node one, plus random cross edges
    set_root(1);
    for (int i = 2; i <= 200; i++) send_item(MODE_EDGE, i, $urandom_range(1, i - 1));
    for (int i = 0; i < 10; i++)
      send_item(MODE_EDGE, $urandom_range(1, NODES - 1), $urandom_range(1, NODES - 1));
    send_item(MODE_BUILD, 0, 0);
    for (int q = 0; q < 40; q++) begin
      if ($urandom_range(0, 99) < 75)
        send_item(MODE_QUERY, $urandom_range(1, 200), $urandom_range(1, 200));
      else
        send_item(MODE_QUERY, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
    end
    settle();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlca_pkg.sv
rtl/tlca_ctrl.sv
rtl/tlca_dpath.sv
rtl/tree_lca_binary_lifting.sv
bench/tb_top.sv
